FILE: sv/tpel_pkg.sv
package tpel_pkg;

    // Subpel position codes carried on the cmd field.
    typedef enum logic [2:0] {
        CMD_H13  = 3'd0,
        CMD_H23  = 3'd1,
        CMD_V13  = 3'd2,
        CMD_V23  = 3'd3,
        CMD_HV11 = 3'd4,
        CMD_HV12 = 3'd5,
        CMD_HV21 = 3'd6,
        CMD_HV22 = 3'd7
    } cmd_t;

    // Tap sets of the separable filter. Unit is (0,16,0,0), which turns a
    // 1D position into the common 2D form with rounding +128 and >>8.
    typedef enum logic [1:0] {
        TAP_ONE_THIRD = 2'd0,
        TAP_TWO_THIRD = 2'd1,
        TAP_CENTER    = 2'd2,
        TAP_UNIT      = 2'd3
    } tap_t;

    localparam int SUM_W = 18;   // vertical sum, signed
    localparam int HOR_W = 14;   // horizontal row sum, signed
    localparam int PIX_W = 8;
    localparam int FRAC_SHIFT = 8;

    localparam logic signed [SUM_W-1:0] K_ONE    = 18'sd1;
    localparam logic signed [SUM_W-1:0] K_SIX    = 18'sd6;
    localparam logic signed [SUM_W-1:0] K_NINE   = 18'sd9;
    localparam logic signed [SUM_W-1:0] K_TWELVE = 18'sd12;
    localparam logic signed [SUM_W-1:0] K_UNIT   = 18'sd16;
    localparam logic signed [SUM_W-1:0] K_ROUND  = 18'sd128;

    // Four-tap weighted sum for the selected tap set.
    function automatic logic signed [SUM_W-1:0] tap_sum(
        input tap_t                    sel,
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b,
        input logic signed [SUM_W-1:0] c,
        input logic signed [SUM_W-1:0] d
    );
        logic signed [SUM_W-1:0] s;
        s = '0;
        unique case (sel)
            TAP_ONE_THIRD: s = K_TWELVE * b + K_SIX * c - a - d;
            TAP_TWO_THIRD: s = K_SIX * b + K_TWELVE * c - a - d;
            TAP_CENTER:    s = K_SIX * b + K_NINE * c + K_ONE * d;
            TAP_UNIT:      s = K_UNIT * b;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/tpel_luma_interp_filter_core.sv
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  cmd, average, four window rows, prior pixel
// m_        out        m_valid / m_ready  pixel_out
//
// Three register stages: row sums, column sum, round/clip/average.
// One word is accepted per cycle while s_ready is high; m_valid is the stage 3 valid bit.
// Throughput is one word per cycle while m_ready stays high; each stage advances on its own.
// Reset (aresetn low, synchronous) clears only the stage valid bits.
// A low m_ready holds the output word; earlier words move up into empty stages,
// and s_ready drops once all three stages are full.
module tpel_luma_interp_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic        s_average,
    input  logic [31:0] s_row_above,
    input  logic [31:0] s_row_center,
    input  logic [31:0] s_row_below,
    input  logic [31:0] s_row_below_two,
    input  logic [7:0]  s_prior_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel_out
);

    localparam int SW = tpel_pkg::SUM_W;
    localparam int HW = tpel_pkg::HOR_W;
    localparam int PW = tpel_pkg::PIX_W;
    localparam int FS = tpel_pkg::FRAC_SHIFT;

    // Stage enables: a stage moves when it is empty or the next one moves.
    logic en1, en2, en3;

    logic                 s1_valid_reg;
    logic signed [HW-1:0] s1_h_reg [4];
    logic signed [HW-1:0] s1_h_next [4];
    tpel_pkg::tap_t       s1_vsel_reg, s1_vsel_next;
    logic                 s1_avg_reg;
    logic [PW-1:0]        s1_prior_reg;

    logic                 s2_valid_reg;
    logic signed [SW-1:0] s2_sum_reg, s2_sum_next;
    logic                 s2_avg_reg;
    logic [PW-1:0]        s2_prior_reg;

    logic                 m_valid_reg;
    logic [PW-1:0]        m_pixel_reg, m_pixel_next;

    tpel_pkg::tap_t       hsel;
    logic [31:0]          rows [4];
    logic signed [SW-1:0] acc;
    logic [SW-FS-1:0]     quot;
    logic [PW-1:0]        clip;
    logic [PW:0]          avg_sum;

    assign en3     = !m_valid_reg || m_ready;
    assign en2     = !s2_valid_reg || en3;
    assign en1     = !s1_valid_reg || en2;
    assign s_ready = en1;
    assign m_valid = m_valid_reg;
    assign m_pixel_out = m_pixel_reg;

    // Decode the position into horizontal and vertical tap sets.
    always_comb begin
        hsel         = tpel_pkg::TAP_UNIT;
        s1_vsel_next = tpel_pkg::TAP_UNIT;
        unique case (tpel_pkg::cmd_t'(s_cmd))
            tpel_pkg::CMD_H13: begin
                hsel = tpel_pkg::TAP_ONE_THIRD; s1_vsel_next = tpel_pkg::TAP_UNIT;
            end
            tpel_pkg::CMD_H23: begin
                hsel = tpel_pkg::TAP_TWO_THIRD; s1_vsel_next = tpel_pkg::TAP_UNIT;
            end
            tpel_pkg::CMD_V13: begin
                hsel = tpel_pkg::TAP_UNIT; s1_vsel_next = tpel_pkg::TAP_ONE_THIRD;
            end
            tpel_pkg::CMD_V23: begin
                hsel = tpel_pkg::TAP_UNIT; s1_vsel_next = tpel_pkg::TAP_TWO_THIRD;
            end
            tpel_pkg::CMD_HV11: begin
                hsel = tpel_pkg::TAP_ONE_THIRD; s1_vsel_next = tpel_pkg::TAP_ONE_THIRD;
            end
            tpel_pkg::CMD_HV12: begin
                hsel = tpel_pkg::TAP_ONE_THIRD; s1_vsel_next = tpel_pkg::TAP_TWO_THIRD;
            end
            tpel_pkg::CMD_HV21: begin
                hsel = tpel_pkg::TAP_TWO_THIRD; s1_vsel_next = tpel_pkg::TAP_ONE_THIRD;
            end
            tpel_pkg::CMD_HV22: begin
                hsel = tpel_pkg::TAP_CENTER; s1_vsel_next = tpel_pkg::TAP_CENTER;
            end
        endcase
    end

    // Stage 1: horizontal filter on each of the four window rows.
    always_comb begin
        rows[0] = s_row_above;
        rows[1] = s_row_center;
        rows[2] = s_row_below;
        rows[3] = s_row_below_two;
        for (int r = 0; r < 4; r++) begin
            s1_h_next[r] = HW'(tpel_pkg::tap_sum(hsel,
                SW'(signed'({1'b0, rows[r][7:0]})),
                SW'(signed'({1'b0, rows[r][15:8]})),
                SW'(signed'({1'b0, rows[r][23:16]})),
                SW'(signed'({1'b0, rows[r][31:24]}))));
        end
    end

    // Stage 2: vertical filter over the row sums.
    assign s2_sum_next = tpel_pkg::tap_sum(s1_vsel_reg,
        SW'(s1_h_reg[0]), SW'(s1_h_reg[1]), SW'(s1_h_reg[2]), SW'(s1_h_reg[3]));

    // Stage 3: round, saturate to a pixel, then optionally average.
    always_comb begin
        acc  = s2_sum_reg + tpel_pkg::K_ROUND;
        quot = acc[SW-1:FS];
        if (acc[SW-1]) begin
            clip = '0;
        end else if (quot > (SW-FS)'({PW{1'b1}})) begin
            clip = '1;
        end else begin
            clip = quot[PW-1:0];
        end
        avg_sum = {1'b0, s2_prior_reg} + {1'b0, clip} + (PW+1)'(1);
        if (s2_avg_reg) begin
            m_pixel_next = avg_sum[PW:1];
        end else begin
            m_pixel_next = clip;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (en1) s1_valid_reg <= s_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) m_valid_reg  <= s2_valid_reg;
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_h_reg     <= s1_h_next;
            s1_vsel_reg  <= s1_vsel_next;
            s1_avg_reg   <= s_average;
            s1_prior_reg <= s_prior_pixel;
        end
        if (en2) begin
            s2_sum_reg   <= s2_sum_next;
            s2_avg_reg   <= s1_avg_reg;
            s2_prior_reg <= s1_prior_reg;
        end
        if (en3) begin
            m_pixel_reg  <= m_pixel_next;
        end
    end

`ifndef SYNTHESIS
    // The input side stalls only when the output holds an untaken word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    // A word in stage 1 that moves on arrives in stage 2.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && en2) |=> s2_valid_reg)
        else $error("word lost between stage 1 and stage 2");

    // A word in stage 2 that moves on arrives at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && en3) |=> m_valid)
        else $error("word lost between stage 2 and output");
`endif

endmodule
